// ----- rtl/core/sbda_pkg.sv -----
// ----------------------------------------------------------------------------
// sbda_pkg
// Shared types and constants for the signed binary to decimal ascii converter
// ----------------------------------------------------------------------------
package sbda_pkg;

  localparam int VALUE_W       = 32;
  localparam int NUM_DIGITS    = 10;
  localparam int BCD_W         = 4 * NUM_DIGITS;
  localparam int BITS_PER_STEP = 4;
  localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
  localparam int QDEPTH        = 2;
  localparam int QAW           = $clog2(QDEPTH);
  localparam int QCW           = $clog2(QDEPTH + 1);

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;

  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- rtl/core/sbda_front.sv -----
// ----------------------------------------------------------------------------
// sbda_front
// Accepts items, splits them into sign and 32-bit magnitude, pushes to queue
// ----------------------------------------------------------------------------
module sbda_front (
  input  logic                          in_valid,
  input  logic signed [sbda_pkg::VALUE_W-1:0] in_value,
  output logic                          in_stall,
  input  sbda_pkg::q_stat_t             q_stat,
  output logic                          q_push,
  output sbda_pkg::entry_t              q_wr_data
);
  import sbda_pkg::*;

  logic [VALUE_W-1:0] raw;

  assign raw            = in_value;
  assign in_stall       = q_stat.full;
  assign q_push         = in_valid && !q_stat.full;
  assign q_wr_data.neg  = raw[VALUE_W-1];
  // most negative value wraps to 2^31, which is its true magnitude
  assign q_wr_data.mag  = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;

endmodule

// ----- rtl/core/sbda_queue.sv -----
// ----------------------------------------------------------------------------
// sbda_queue
// Short queue between front and back parts
// ----------------------------------------------------------------------------
module sbda_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_push,
  input  sbda_pkg::entry_t     q_wr_data,
  input  logic                 q_pop,
  output sbda_pkg::entry_t     q_rd_data,
  output sbda_pkg::q_stat_t    q_stat
);
  import sbda_pkg::*;

  entry_t           mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   count_r, count_nxt;

  function automatic logic [QAW-1:0] ptr_inc(input logic [QAW-1:0] p);
    ptr_inc = (p == QAW'(QDEPTH - 1)) ? '0 : p + QAW'(1);
  endfunction

  assign q_stat.full  = (count_r == QCW'(QDEPTH));
  assign q_stat.empty = (count_r == '0);
  assign q_rd_data    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = q_push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (q_push && !q_pop) begin
      count_nxt = count_r + QCW'(1);
    end else if (!q_push && q_pop) begin
      count_nxt = count_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      mem_r[wr_ptr_r] <= q_wr_data;
    end
  end

endmodule

// ----- rtl/core/sbda_back.sv -----
// ----------------------------------------------------------------------------
// sbda_back
// Double dabble conversion, four bits a cycle, then one character per cycle unless the output stalls
// ----------------------------------------------------------------------------
module sbda_back (
  input  logic              clk,
  input  logic              rst_n,
  input  sbda_pkg::q_stat_t q_stat,
  input  sbda_pkg::entry_t  q_rd_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_character,
  output logic              out_last,
  output logic [3:0]        out_length
);
  import sbda_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_SIZE, ST_EMIT} state_t;

  localparam int CNT_W = $clog2(CONV_STEPS);

  state_t                  state_r, state_nxt;
  logic [BCD_W-1:0]        bcd_r, bcd_nxt;
  logic [VALUE_W-1:0]      sh_r, sh_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    neg_r, neg_nxt;
  logic                    sign_pend_r, sign_pend_nxt;
  logic [3:0]              dig_r, dig_nxt;
  logic [3:0]              total_r, total_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [7:0]              out_character_r, out_character_nxt;
  logic                    out_last_r, out_last_nxt;
  logic [3:0]              out_length_r, out_length_nxt;

  logic [BCD_W-1:0]        step_bcd;
  logic [VALUE_W-1:0]      step_sh;
  logic [3:0]              top;
  logic                    slot_free;
  logic [3:0]              cur_digit;

  assign slot_free = !out_valid_r || !out_stall;
  assign cur_digit = bcd_r[{dig_r, 2'b00} +: 4];
  assign q_pop     = (state_r == ST_IDLE) && !q_stat.empty;

  // four shift-and-correct steps
  always_comb begin
    step_bcd = bcd_r;
    step_sh  = sh_r;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (step_bcd[4*d +: 4] >= 4'd5) begin
          step_bcd[4*d +: 4] = step_bcd[4*d +: 4] + 4'd3;
        end
      end
      step_bcd = {step_bcd[BCD_W-2:0], step_sh[VALUE_W-1]};
      step_sh  = {step_sh[VALUE_W-2:0], 1'b0};
    end
  end

  // leading nonzero digit
  always_comb begin
    top = '0;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd_r[4*d +: 4] != 4'd0) begin
        top = 4'(d);
      end
    end
  end

  always_comb begin
    state_nxt         = state_r;
    bcd_nxt           = bcd_r;
    sh_nxt            = sh_r;
    cnt_nxt           = cnt_r;
    neg_nxt           = neg_r;
    sign_pend_nxt     = sign_pend_r;
    dig_nxt           = dig_r;
    total_nxt         = total_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_character_nxt = out_character_r;
    out_last_nxt      = out_last_r;
    out_length_nxt    = out_length_r;
    case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          neg_nxt   = q_rd_data.neg;
          sh_nxt    = q_rd_data.mag;
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_nxt = step_bcd;
        sh_nxt  = step_sh;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(CONV_STEPS - 1)) begin
          state_nxt = ST_SIZE;
        end
      end
      ST_SIZE: begin
        dig_nxt       = top;
        sign_pend_nxt = neg_r;
        total_nxt     = top + 4'd1 + {3'b000, neg_r};
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (sign_pend_r) begin
            out_character_nxt = ASCII_MINUS;
            out_last_nxt      = 1'b0;
            out_length_nxt    = '0;
            sign_pend_nxt     = 1'b0;
          end else begin
            out_character_nxt = ASCII_ZERO + {4'b0000, cur_digit};
            out_last_nxt      = (dig_r == 4'd0);
            out_length_nxt    = (dig_r == 4'd0) ? total_r : 4'd0;
            if (dig_r == 4'd0) begin
              state_nxt = ST_IDLE;
            end else begin
              dig_nxt = dig_r - 4'd1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      out_valid_r     <= out_valid_nxt;
      bcd_r           <= bcd_nxt;
      sh_r            <= sh_nxt;
      cnt_r           <= cnt_nxt;
      neg_r           <= neg_nxt;
      sign_pend_r     <= sign_pend_nxt;
      dig_r           <= dig_nxt;
      total_r         <= total_nxt;
      out_character_r <= out_character_nxt;
      out_last_r      <= out_last_nxt;
      out_length_r    <= out_length_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_last      = out_last_r;
  assign out_length    = out_length_r;

endmodule

// ----- rtl/core/signed_binary_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii
// Signed 32-bit integer to decimal ascii text, one character per item out
// ----------------------------------------------------------------------------
//  channel  direction  ports                                   handshake
//  in       input      in_value                                in_valid / in_stall
//  out      output     out_character, out_last, out_length     out_valid / out_stall
//
//  each number passes the back part in steps (load, double dabble at four
//  bits a cycle, digit count), then one character per cycle unless out stalls, 1 to 11
//  a two-entry queue lets the front take new items while the back converts
//  stall on the out side holds the character register and the back part's character output
//  reset (rst_n low, synchronous) empties the queue and the output register
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic signed [sbda_pkg::VALUE_W-1:0] in_value,
  output logic                               in_stall,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         out_character,
  output logic                               out_last,
  output logic [3:0]                         out_length
);
  import sbda_pkg::*;

  q_stat_t q_stat;
  entry_t  q_wr_data;
  entry_t  q_rd_data;
  logic    q_push;
  logic    q_pop;

  sbda_front u_front (
    .in_valid  (in_valid),
    .in_value  (in_value),
    .in_stall  (in_stall),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wr_data (q_wr_data)
  );

  sbda_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_push    (q_push),
    .q_wr_data (q_wr_data),
    .q_pop     (q_pop),
    .q_rd_data (q_rd_data),
    .q_stat    (q_stat)
  );

  sbda_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_stat        (q_stat),
    .q_rd_data     (q_rd_data),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last),
    .out_length    (out_length)
  );

`ifndef SYNTHESIS
  a_len_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_length != 4'd0 && out_length <= 4'd11)
    else $error("bad length on last character");

  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_length == 4'd0)
    else $error("length set on non-final character");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_character == ASCII_MINUS |-> !out_last)
    else $error("minus sign flagged as last");

  a_queue_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty at once");
`endif

endmodule
